// ===== src/epoch_cal_pkg.sv =====
// Constants, types and helpers shared by the epoch seconds to calendar converter.
package epoch_cal_pkg;

  // Port types of the request and the result
  typedef logic [31:0] secs_t;
  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [2:0]  wday_t;

  // Whole days and remainder: days = (secs >> 7) * DAY_MAGIC >> DAY_SHIFT, exact below 2^32
  localparam logic [25:0] DAY_MAGIC    = 26'd50903317;
  localparam int          DAY_SHIFT    = 35;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // Hour of day: (rem >> 4) * HOUR_MAGIC >> 20, exact below 86400
  localparam logic [12:0] HOUR_MAGIC    = 13'd4661;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // Minute of hour: (rem >> 2) * MIN_MAGIC >> 14, exact below 3600
  localparam logic [10:0] MIN_MAGIC    = 11'd1093;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  // Weekday: (days + 4) mod 7, quotient by WDAY_MAGIC >> 19, exact below 2^16
  localparam logic [15:0] WDAY_OFFSET   = 16'd4;
  localparam logic [16:0] WDAY_MAGIC    = 17'd74899;
  localparam logic [15:0] DAYS_PER_WEEK = 16'd7;

  // Four-year cycles counted from 1968-01-01, a leap year
  localparam logic [15:0] EPOCH_OFFSET = 16'd731;   // days from 1968-01-01 to 1970-01-01
  localparam logic [15:0] SKIP_DAY     = 16'd48272; // 2100-03-01: 2100 has no 29 February
  localparam logic [15:0] CYC_MAGIC    = 16'd45934; // quotient by 1461 is product >> 26
  localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
  localparam logic [11:0] BASE_YEAR    = 12'd1968;

  // First day of each year within a four-year cycle
  localparam logic [10:0] YEAR_START [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};

  // First day of each month in a common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Day of year on which a month begins, March onwards shifted by one in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    base = MONTH_START[idx];
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== src/epoch_seconds_to_calendar_top.sv =====
// An accepted request (start high, busy low) runs through the register stages to the done strobe.
// Throughput: one request per cycle; busy stays low, the results leave in request order.
// Every stage takes a new request each cycle, so the 11 register stages set the latency only.
// Reset (rst, synchronous, active high) clears the stage valid bits; no request is in flight.
// Results are shown for one cycle only, since the receiver cannot stall.
module epoch_seconds_to_calendar_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  epoch_cal_pkg::secs_t    epoch_seconds,
  output logic                    done,
  output epoch_cal_pkg::year_t    cal_year,
  output epoch_cal_pkg::month_t   cal_month,
  output epoch_cal_pkg::day_t     cal_day,
  output epoch_cal_pkg::hour_t    cal_hour,
  output epoch_cal_pkg::minute_t  cal_minute,
  output epoch_cal_pkg::second_t  cal_second,
  output epoch_cal_pkg::wday_t    day_of_week
);
  import epoch_cal_pkg::*;

  localparam int LAT = 11;

  logic [LAT-1:0] vld;

  // stage registers
  logic [31:0] secs1, secs2, secs3, secs4;
  logic [50:0] pday2;
  logic [15:0] days3;
  logic [31:0] dsec4;
  logic [31:0] wprod4;
  logic [15:0] wn4, wn5;
  logic [15:0] adj4, adj5, adj6, adj7;
  logic [16:0] rem5, rem6, rem7;
  logic [12:0] wq5;
  logic [31:0] cprod5;
  logic [24:0] hprod6;
  logic [2:0]  wd6, wd7, wd8, wd9, wd10;
  logic [5:0]  c6, c7, c8;
  logic [4:0]  hour7, hour8, hour9, hour10;
  logic [15:0] cdays7;
  logic [11:0] remhr8, remhr9, remhr10;
  logic [10:0] r8;
  logic [19:0] mprod9;
  logic [11:0] year9, year10;
  logic [8:0]  doy9, doy10;
  logic        leap9, leap10;
  logic [5:0]  min10;
  logic [3:0]  mon10;

  // combinational helpers
  logic [31:0] dsec_full;
  logic [15:0] wn_c;
  logic [15:0] dp_c;
  logic [16:0] hsec_c;
  logic [1:0]  yq_c;
  logic [10:0] ydoy_c;
  logic [11:0] year_c;
  logic [3:0]  mon_c;
  logic [11:0] msec_c;
  logic [8:0]  dstart_c;

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // Advance the valid bits with the requests
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  // Split into days, and a four-year cycle origin for the year search
  always_comb begin
    dsec_full = 32'(days3) * 32'(SECS_PER_DAY);
    wn_c      = days3 + WDAY_OFFSET;
    dp_c      = days3 + EPOCH_OFFSET;
    hsec_c    = 17'(hour7) * 17'(SECS_PER_HOUR);
  end

  // Pick the year within the cycle and its day of year
  always_comb begin
    yq_c   = 2'd0;
    ydoy_c = r8;
    for (int i = 1; i < 4; i++) begin
      if (r8 >= YEAR_START[i]) begin
        yq_c   = 2'(i);
        ydoy_c = r8 - YEAR_START[i];
      end
    end
    year_c = BASE_YEAR + 12'({c8, 2'b00}) + 12'(yq_c);
  end

  // Find the month: last month whose first day is not after the day of year
  always_comb begin
    mon_c = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (doy9 >= month_start(4'(i), leap9)) begin
        mon_c = 4'(i + 1);
      end
    end
    msec_c   = 12'(min10) * 12'(SECS_PER_MIN);
    dstart_c = month_start(mon10 - 4'd1, leap10);
  end

  // Pipeline data path
  always_ff @(posedge clk) begin
    // stage 1: capture the request
    secs1 <= epoch_seconds;

    // stage 2: day quotient product
    pday2 <= 51'(secs1[31:7]) * 51'(DAY_MAGIC);
    secs2 <= secs1;

    // stage 3: whole days
    days3 <= pday2[50:35];
    secs3 <= secs2;

    // stage 4: seconds in whole days, weekday product, cycle-origin day count
    dsec4  <= dsec_full;
    secs4  <= secs3;
    wn4    <= wn_c;
    wprod4 <= 32'(wn_c) * 32'(WDAY_MAGIC);
    adj4   <= dp_c + 16'(dp_c >= SKIP_DAY);

    // stage 5: seconds of day, weekday quotient, cycle product
    rem5   <= 17'(secs4 - dsec4);
    wq5    <= wprod4[31:19];
    wn5    <= wn4;
    cprod5 <= 32'(adj4) * 32'(CYC_MAGIC);
    adj5   <= adj4;

    // stage 6: hour product, weekday, cycle count
    hprod6 <= 25'(rem5[16:4]) * 25'(HOUR_MAGIC);
    rem6   <= rem5;
    wd6    <= 3'(wn5 - 16'(wq5) * DAYS_PER_WEEK);
    c6     <= cprod5[31:26];
    adj6   <= adj5;

    // stage 7: hour, days in whole cycles
    hour7  <= hprod6[24:20];
    rem7   <= rem6;
    wd7    <= wd6;
    cdays7 <= 16'(c6) * 16'(CYCLE_DAYS);
    c7     <= c6;
    adj7   <= adj6;

    // stage 8: seconds of hour, day within the cycle
    remhr8 <= 12'(rem7 - hsec_c);
    hour8  <= hour7;
    wd8    <= wd7;
    r8     <= 11'(adj7 - cdays7);
    c8     <= c7;

    // stage 9: minute product, year and day of year
    mprod9 <= 20'(remhr8[11:2]) * 20'(MIN_MAGIC);
    remhr9 <= remhr8;
    hour9  <= hour8;
    wd9    <= wd8;
    year9  <= year_c;
    doy9   <= 9'(ydoy_c);
    leap9  <= (yq_c == 2'd0);

    // stage 10: minute, month
    min10   <= mprod9[19:14];
    remhr10 <= remhr9;
    hour10  <= hour9;
    wd10    <= wd9;
    year10  <= year9;
    doy10   <= doy9;
    leap10  <= leap9;
    mon10   <= mon_c;

    // stage 11: result registers
    cal_second  <= 6'(remhr10 - msec_c);
    cal_minute  <= min10;
    cal_hour    <= hour10;
    day_of_week <= wd10;
    cal_year    <= year10;
    cal_month   <= mon10;
    cal_day     <= 5'(doy10 - dstart_c + 9'd1);
  end

  // Each result follows its request by the pipeline latency
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  // Time of day fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cal_hour < 5'd24) && (cal_minute < 6'd60) && (cal_second < 6'd60))
    else $error("time of day out of range");

  // Date fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cal_month >= 4'd1) && (cal_month <= 4'd12) && (cal_day >= 5'd1) &&
             (day_of_week <= 3'd6) && (cal_year >= 12'd1970) && (cal_year <= 12'd2106))
    else $error("date out of range");

  // February never runs past the 29th
  a_feb_len: assert property (@(posedge clk) disable iff (rst)
    (done && (cal_month == 4'd2)) |-> (cal_day <= 5'd29))
    else $error("February day out of range");

endmodule
